FILE: rtl/magnetic_presence_detector_core_macros.svh
// Assertion helpers for the detector core RTL.
`ifndef MAGNETIC_PRESENCE_DETECTOR_CORE_MACROS_SVH
`define MAGNETIC_PRESENCE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication on clk, masked during reset
`define MPD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpd assertion failed");

// next-cycle implication on clk, masked during reset
`define MPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpd assertion failed");

`endif

FILE: rtl/mpd_pkg.sv
package mpd_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF    = 8;
	localparam int COUNT_WIDTH_DEF  = 32;

	localparam int MEAN_EXTRA = 16;
	localparam int M2_SHIFT   = 12;
	localparam int M2_W       = 64;
	localparam int NOISE_W    = 32;
	localparam int DEV_W      = 24;
	localparam int EV_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int TIME_W     = 32;

	typedef enum logic [EV_W-1:0] {
		EV_NONE        = 3'd0,
		EV_CALIBRATING = 3'd1,
		EV_CAL_DONE    = 3'd2,
		EV_DETECTED    = 3'd3,
		EV_CLEARED     = 3'd4
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_TIME = 3'd0,
		REG_ABS_TH   = 3'd1,
		REG_K_SIGMA  = 3'd2,
		REG_ALPHA    = 3'd3,
		REG_HYST     = 3'd4,
		REG_N_HIGH   = 3'd5,
		REG_N_LOW    = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] CAL_TIME_RST = 16'd5000;
	localparam logic [22:0] ABS_TH_RST   = 23'd2560;
	localparam logic [11:0] K_SIGMA_RST  = 12'd1024;
	localparam logic [15:0] ALPHA_RST    = 16'd655;
	localparam logic [15:0] HYST_RST     = 16'd32768;
	localparam logic [7:0]  N_HIGH_RST   = 8'd3;
	localparam logic [7:0]  N_LOW_RST    = 8'd5;

endpackage

FILE: rtl/magnetic_presence_detector_core.sv
// Magnetic presence detector. Each request carries a signed magnitude sample and a ms
// timestamp and yields exactly one result. During the calibration window (from the first
// sample's time) a running Welford mean/M2 is kept; the first sample past the window sets
// baseline, noise and detect threshold; later samples report |sample - baseline| and drive
// a consecutive-sample hysteresis. One request is worked at a time through a shared
// multiplier, a 1-bit-per-cycle divider and a 2-bit-per-cycle square root. A calibrating
// sample runs 64 divider steps, the window-closing sample up to 64 divider plus 32 root
// steps, and a tracking sample neither; each result may then wait on m_tready before the
// next request is accepted.
`include "magnetic_presence_detector_core_macros.svh"

module magnetic_presence_detector_core #(
	parameter int SAMPLE_WIDTH = mpd_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = mpd_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH  = mpd_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// sample, time_ms
	input  logic [((SAMPLE_WIDTH+mpd_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// event_res, deviation, baseline_out
	output logic [55:0] m_tdata
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int XS_W  = SW + mpd_pkg::MEAN_EXTRA;
	localparam int D_W   = XS_W + 1;
	localparam int Q_W   = D_W - mpd_pkg::M2_SHIFT;
	localparam int MW    = (Q_W + 1 > 33) ? Q_W + 1 : 33;
	localparam int PW    = 2 * MW;
	localparam int TH_W  = PW - 12;
	localparam int DH_W  = D_W - mpd_pkg::MEAN_EXTRA;
	localparam int MG_W  = (DH_W > mpd_pkg::DEV_W + 1) ? DH_W : mpd_pkg::DEV_W + 1;
	localparam int BX_W  = (XS_W > 40) ? XS_W : 40;
	localparam int CW    = COUNT_WIDTH;
	localparam int M2W   = mpd_pkg::M2_W;
	localparam int OUT_W = 56;
	localparam int PAD_W = OUT_W - mpd_pkg::EV_W - 2 * mpd_pkg::DEV_W;
	localparam logic [mpd_pkg::NOISE_W-1:0] NOISE_DEF = mpd_pkg::NOISE_W'(1) << (FRAC_BITS + 3);

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_CAL_DIV  = 14'b00000000000010,
		ST_CAL_MUL  = 14'b00000000000100,
		ST_CAL_ACC  = 14'b00000000001000,
		ST_FIN_DIV  = 14'b00000000010000,
		ST_FIN_SQRT = 14'b00000000100000,
		ST_FIN_MUL  = 14'b00000001000000,
		ST_FIN_TH   = 14'b00000010000000,
		ST_RUN_DIFF = 14'b00000100000000,
		ST_RUN_MUL1 = 14'b00001000000000,
		ST_RUN_MUL2 = 14'b00010000000000,
		ST_RUN_MUL3 = 14'b00100000000000,
		ST_RUN_DEC  = 14'b01000000000000,
		ST_OUT      = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [15:0] cal_time_q, alpha_q, hyst_q;
	logic [22:0] abs_th_q;
	logic [11:0] k_q;
	logic [7:0]  n_high_q, n_low_q;

	logic started_q, calibrated_q, event_active_q;
	logic [mpd_pkg::TIME_W-1:0] start_q;
	logic [CW-1:0] count_q;
	logic signed [XS_W-1:0] mean_q, baseline_q;
	logic [M2W-1:0] m2_q;
	logic [mpd_pkg::DEV_W-1:0] thr_q;
	logic [7:0] high_run_q, low_run_q;

	logic [SW-1:0] sample_q;
	logic signed [D_W-1:0] d_q;
	logic same_q;
	logic [mpd_pkg::NOISE_W-1:0] noise_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic [mpd_pkg::DEV_W-1:0] dev_q;
	mpd_pkg::ev_t ev_q;
	logic [5:0] step_q;

	logic [M2W-1:0] quo_q;
	logic [CW-1:0] rem_q, den_q;
	logic [M2W-1:0] sq_v_q, sq_res_q, sq_bit_q;

	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// input decode
	logic signed [SW-1:0] in_x;
	logic [mpd_pkg::TIME_W-1:0] in_t, st_eff;
	logic signed [XS_W-1:0] in_xs, xs;
	logic in_win;
	logic [CW-1:0] count_inc;
	logic signed [D_W-1:0] d1_in, d_cur;
	logic [D_W-1:0] d1_mag;

	assign in_x   = $signed(s_tdata[SW-1:0]);
	assign in_t   = s_tdata[SW+mpd_pkg::TIME_W-1:SW];
	assign st_eff = started_q ? start_q : in_t;
	assign in_win = (in_t - st_eff) < mpd_pkg::TIME_W'(cal_time_q);
	assign in_xs  = $signed({in_x, {mpd_pkg::MEAN_EXTRA{1'b0}}});
	assign xs     = $signed({sample_q, {mpd_pkg::MEAN_EXTRA{1'b0}}});
	assign count_inc = (&count_q) ? count_q : count_q + CW'(1);
	assign d1_in  = D_W'(in_xs) - D_W'(mean_q);
	assign d1_mag = d1_in[D_W-1] ? D_W'(-d1_in) : D_W'(d1_in);
	// against the new mean in calibration, against the baseline when tracking
	assign d_cur  = D_W'(xs) - D_W'(calibrated_q ? baseline_q : mean_q);

	// restoring divider step
	logic [CW:0] trial;
	logic take;
	logic [CW-1:0] rem_next;
	logic [M2W-1:0] quo_next;

	assign trial    = {rem_q, quo_q[M2W-1]};
	assign take     = trial >= {1'b0, den_q};
	assign rem_next = take ? CW'(trial - {1'b0, den_q}) : CW'(trial);
	assign quo_next = {quo_q[M2W-2:0], take};

	// square root step
	logic [M2W-1:0] sq_sum;
	logic sq_take;
	assign sq_sum  = sq_res_q + sq_bit_q;
	assign sq_take = sq_v_q >= sq_sum;

	// signed quotient for the mean update (truncates toward zero)
	logic signed [D_W-1:0] mq;
	logic signed [XS_W-1:0] mean_new;
	assign mq       = d_q[D_W-1] ? -$signed(D_W'(quo_next)) : $signed(D_W'(quo_next));
	assign mean_new = XS_W'(D_W'(mean_q) + mq);

	// Welford product operands (floor shift)
	logic signed [Q_W-1:0] q1, q2;
	logic [Q_W-1:0] q1_mag, q2_mag;
	assign q1     = Q_W'(d_q >>> mpd_pkg::M2_SHIFT);
	assign q2     = Q_W'(d_cur >>> mpd_pkg::M2_SHIFT);
	assign q1_mag = q1[Q_W-1] ? Q_W'(-q1) : Q_W'(q1);
	assign q2_mag = q2[Q_W-1] ? Q_W'(-q2) : Q_W'(q2);

	logic signed [DH_W-1:0] dh;
	assign dh = DH_W'(d_q >>> mpd_pkg::MEAN_EXTRA);

	// shared multiplier, product registered
	logic signed [MW-1:0] mul_a, mul_b;
	always_comb begin
		case (state_q)
			ST_CAL_MUL: begin
				mul_a = $signed(MW'(q1_mag));
				mul_b = $signed(MW'(q2_mag));
			end
			ST_FIN_MUL: begin
				mul_a = $signed(MW'(k_q));
				mul_b = $signed(MW'(noise_q));
			end
			ST_RUN_MUL1: begin
				mul_a = MW'(dh);
				mul_b = $signed(MW'(alpha_q));
			end
			ST_RUN_MUL2: begin
				mul_a = $signed(MW'(d_q[15:0]));
				mul_b = $signed(MW'(alpha_q));
			end
			ST_RUN_MUL3: begin
				mul_a = $signed(MW'(thr_q));
				mul_b = $signed(MW'(hyst_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Welford term with saturation, then saturating M2 add
	logic [M2W-1:0] term;
	logic [M2W:0] m2_sum;
	assign term   = !same_q ? '0 : (|prod_q[PW-1:M2W]) ? '1 : prod_q[M2W-1:0];
	assign m2_sum = {1'b0, m2_q} + {1'b0, term};

	// threshold from noise
	logic [TH_W-1:0] th_raw, th_max;
	logic [mpd_pkg::DEV_W-1:0] th_sat;
	assign th_raw = prod_q[PW-1:12];
	assign th_max = (th_raw < TH_W'(abs_th_q)) ? TH_W'(abs_th_q) : th_raw;
	assign th_sat = (|th_max[TH_W-1:mpd_pkg::DEV_W]) ? '1 : th_max[mpd_pkg::DEV_W-1:0];

	// deviation
	logic [D_W-1:0] mag;
	logic [MG_W-1:0] mag_hi;
	logic [mpd_pkg::DEV_W-1:0] dev_sat;
	assign mag     = d_cur[D_W-1] ? D_W'(-d_cur) : D_W'(d_cur);
	assign mag_hi  = MG_W'(mag[D_W-1:mpd_pkg::MEAN_EXTRA]);
	assign dev_sat = (|mag_hi[MG_W-1:mpd_pkg::DEV_W]) ? '1 : mag_hi[mpd_pkg::DEV_W-1:0];

	logic [mpd_pkg::DEV_W-1:0] low_th;
	assign low_th = prod_q[39:16];

	logic [7:0] high_inc, low_inc;
	assign high_inc = (&high_run_q) ? high_run_q : high_run_q + 8'd1;
	assign low_inc  = (&low_run_q) ? low_run_q : low_run_q + 8'd1;

	logic signed [BX_W-1:0] base_x;
	assign base_x = BX_W'(baseline_q);

	logic out_cal_ev;
	assign out_cal_ev = (m_tdata[2:0] == mpd_pkg::EV_CALIBRATING) ||
	                    (m_tdata[2:0] == mpd_pkg::EV_CAL_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_time_q     <= mpd_pkg::CAL_TIME_RST;
			abs_th_q       <= mpd_pkg::ABS_TH_RST;
			k_q            <= mpd_pkg::K_SIGMA_RST;
			alpha_q        <= mpd_pkg::ALPHA_RST;
			hyst_q         <= mpd_pkg::HYST_RST;
			n_high_q       <= mpd_pkg::N_HIGH_RST;
			n_low_q        <= mpd_pkg::N_LOW_RST;
			state_q        <= ST_IDLE;
			started_q      <= 1'b0;
			calibrated_q   <= 1'b0;
			event_active_q <= 1'b0;
			start_q        <= '0;
			count_q        <= '0;
			mean_q         <= '0;
			baseline_q     <= '0;
			m2_q           <= '0;
			thr_q          <= '0;
			high_run_q     <= '0;
			low_run_q      <= '0;
			m_tvalid_q     <= 1'b0;
			step_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpd_pkg::REG_CAL_TIME: cal_time_q <= cfg_wdata[15:0];
					mpd_pkg::REG_ABS_TH:   abs_th_q <= cfg_wdata;
					mpd_pkg::REG_K_SIGMA:  k_q <= cfg_wdata[11:0];
					mpd_pkg::REG_ALPHA:    alpha_q <= cfg_wdata[15:0];
					mpd_pkg::REG_HYST:     hyst_q <= cfg_wdata[15:0];
					mpd_pkg::REG_N_HIGH:   n_high_q <= cfg_wdata[7:0];
					mpd_pkg::REG_N_LOW:    n_low_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sample_q <= s_tdata[SW-1:0];
						step_q   <= '0;
						rem_q    <= '0;
						if (calibrated_q) begin
							state_q <= ST_RUN_DIFF;
						end else begin
							started_q <= 1'b1;
							start_q   <= st_eff;
							if (in_win) begin
								count_q <= count_inc;
								d_q     <= d1_in;
								quo_q   <= M2W'(d1_mag);
								den_q   <= count_inc;
								state_q <= ST_CAL_DIV;
							end else begin
								baseline_q <= mean_q;
								if (count_q > CW'(1)) begin
									quo_q   <= m2_q;
									den_q   <= count_q - CW'(1);
									state_q <= ST_FIN_DIV;
								end else begin
									noise_q <= NOISE_DEF;
									state_q <= ST_FIN_MUL;
								end
							end
						end
					end
				end
				ST_CAL_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + 6'd1;
					if (&step_q) begin
						mean_q  <= mean_new;
						state_q <= ST_CAL_MUL;
					end
				end
				ST_CAL_MUL: begin
					same_q  <= (!q1[Q_W-1] && |q1 && !q2[Q_W-1] && |q2) ||
					           (q1[Q_W-1] && q2[Q_W-1]);
					state_q <= ST_CAL_ACC;
				end
				ST_CAL_ACC: begin
					m2_q    <= m2_sum[M2W] ? '1 : m2_sum[M2W-1:0];
					ev_q    <= mpd_pkg::EV_CALIBRATING;
					dev_q   <= '0;
					state_q <= ST_OUT;
				end
				ST_FIN_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + 6'd1;
					if (&step_q) begin
						sq_v_q   <= quo_next;
						sq_res_q <= '0;
						sq_bit_q <= M2W'(1) << (M2W - 2);
						state_q  <= ST_FIN_SQRT;
					end
				end
				ST_FIN_SQRT: begin
					if (sq_take) begin
						sq_v_q   <= sq_v_q - sq_sum;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					step_q   <= step_q + 6'd1;
					if (step_q == 6'd31) begin
						noise_q <= sq_take ? mpd_pkg::NOISE_W'((sq_res_q >> 1) + sq_bit_q)
						                   : mpd_pkg::NOISE_W'(sq_res_q >> 1);
						state_q <= ST_FIN_MUL;
					end
				end
				ST_FIN_MUL: begin
					state_q <= ST_FIN_TH;
				end
				ST_FIN_TH: begin
					thr_q        <= th_sat;
					calibrated_q <= 1'b1;
					ev_q         <= mpd_pkg::EV_CAL_DONE;
					dev_q        <= '0;
					state_q      <= ST_OUT;
				end
				ST_RUN_DIFF: begin
					d_q     <= d_cur;
					dev_q   <= dev_sat;
					state_q <= ST_RUN_MUL1;
				end
				ST_RUN_MUL1: begin
					state_q <= ST_RUN_MUL2;
				end
				ST_RUN_MUL2: begin
					acc_q   <= prod_q;
					state_q <= ST_RUN_MUL3;
				end
				ST_RUN_MUL3: begin
					acc_q   <= acc_q + $signed(PW'(prod_q[31:16]));
					state_q <= ST_RUN_DEC;
				end
				ST_RUN_DEC: begin
					if (!event_active_q) begin
						baseline_q <= XS_W'(PW'(baseline_q) + acc_q);
						if (dev_q >= thr_q) begin
							if (high_inc >= n_high_q) begin
								event_active_q <= 1'b1;
								high_run_q     <= '0;
								low_run_q      <= '0;
								ev_q           <= mpd_pkg::EV_DETECTED;
							end else begin
								high_run_q <= high_inc;
								ev_q       <= mpd_pkg::EV_NONE;
							end
						end else begin
							high_run_q <= '0;
							ev_q       <= mpd_pkg::EV_NONE;
						end
					end else begin
						if (dev_q <= low_th) begin
							if (low_inc >= n_low_q) begin
								event_active_q <= 1'b0;
								high_run_q     <= '0;
								low_run_q      <= '0;
								ev_q           <= mpd_pkg::EV_CLEARED;
							end else begin
								low_run_q <= low_inc;
								ev_q      <= mpd_pkg::EV_NONE;
							end
						end else begin
							low_run_q <= '0;
							ev_q      <= mpd_pkg::EV_NONE;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q <= {{PAD_W{1'b0}}, base_x[39:16], dev_q, ev_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
	end

	`MPD_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != ST_IDLE)
	`MPD_ASSERT_NOW(a_cal_dev_zero, m_tvalid && out_cal_ev, m_tdata[26:3] == 24'd0)
	`MPD_ASSERT_NOW(a_no_event_uncal, !calibrated_q, !event_active_q)
	`MPD_ASSERT_NOW(a_event_rise_out, $rose(event_active_q), state_q == ST_OUT && ev_q == mpd_pkg::EV_DETECTED)
	`MPD_ASSERT_NOW(a_cal_rise_out, $rose(calibrated_q), state_q == ST_OUT && ev_q == mpd_pkg::EV_CAL_DONE)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef struct {
		mpd_pkg::ev_t ev;
		logic [23:0]  dev;
		logic [23:0]  base;
	} result_t;

	typedef struct {
		bit          rel;    // sample is an offset from the current baseline
		int          smp;
		logic [31:0] t;
		bit          typed;
		result_t     res;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mpd_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [55:0] m_tdata;

	magnetic_presence_detector_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// detector copy: registers
	bit [15:0] c_cal;
	bit [22:0] c_abs;
	bit [11:0] c_k;
	bit [15:0] c_alpha, c_hyst;
	bit [7:0]  c_nh, c_nl;
	// detector copy: state
	bit        started, calibrated, active;
	bit [31:0] t0, cnt, dth;
	longint    mean, base;
	bit [63:0] m2;
	int        hrun, lrun;

	result_t pending[$];
	int      errors = 0;
	int      mode = 0;
	bit      vld_on = 0;
	int      burst_left = 0;
	int      burst_sign = 1;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("magnetic_presence_detector_core: mismatch");
		$finish;
	end

	function automatic bit [63:0] sat_mul(bit [63:0] a, bit [63:0] b);
		bit [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic detect_step(input logic [23:0] smp, input logic [31:0] t, output result_t r);
		longint xs, d1, d2, q1, q2, diff, dh, dl, bsh;
		bit [63:0] term, noise, th, mag, lth, dv;
		bit [64:0] acc;
		bit [31:0] elapsed;
		xs = longint'($signed(smp)) * 65536;
		r.ev = mpd_pkg::EV_NONE;
		r.dev = 0;
		if (!calibrated) begin
			if (!started) begin
				started = 1;
				t0 = t;
			end
			elapsed = t - t0;
			if (elapsed < {16'b0, c_cal}) begin
				if (cnt != 32'hFFFF_FFFF)
					cnt++;
				d1 = xs - mean;
				mean += d1 / longint'(cnt);
				d2 = xs - mean;
				q1 = d1 >>> 12;
				q2 = d2 >>> 12;
				term = 0;
				if (q1 > 0 && q2 > 0)
					term = sat_mul(q1, q2);
				else if (q1 < 0 && q2 < 0)
					term = sat_mul(-q1, -q2);
				acc = {1'b0, m2} + {1'b0, term};
				m2 = acc[64] ? '1 : acc[63:0];
				r.ev = mpd_pkg::EV_CALIBRATING;
			end else begin
				base = mean;
				if (cnt > 1)
					noise = int_sqrt(m2 / {32'b0, cnt - 32'd1});
				else
					noise = 64'd1 << 11;
				th = ({52'b0, c_k} * noise) >> 12;
				if (th < c_abs)
					th = c_abs;
				if (th > 64'hFF_FFFF)
					th = 64'hFF_FFFF;
				dth = th[31:0];
				calibrated = 1;
				r.ev = mpd_pkg::EV_CAL_DONE;
			end
		end else begin
			diff = xs - base;
			mag = (diff < 0) ? -diff : diff;
			lth = ({32'b0, dth} * {48'b0, c_hyst}) >> 16;
			dv = mag >> 16;
			if (dv > 64'hFF_FFFF)
				dv = 64'hFF_FFFF;
			r.dev = dv[23:0];
			if (!active) begin
				dh = diff >>> 16;
				dl = diff - dh * 65536;
				base += dh * longint'(c_alpha) + longint'((dl * c_alpha) >> 16);
				if (dv >= dth) begin
					if (hrun < 255)
						hrun++;
					if (hrun >= c_nh) begin
						active = 1;
						hrun = 0;
						lrun = 0;
						r.ev = mpd_pkg::EV_DETECTED;
					end
				end else begin
					hrun = 0;
				end
			end else begin
				if (dv <= lth) begin
					if (lrun < 255)
						lrun++;
					if (lrun >= c_nl) begin
						active = 0;
						lrun = 0;
						hrun = 0;
						r.ev = mpd_pkg::EV_CLEARED;
					end
				end else begin
					lrun = 0;
				end
			end
		end
		bsh = base >>> 16;
		r.base = bsh[23:0];
	endtask

	// all seven registers, written back to back; block must be idle
	task automatic write_regs(input int cal, abs_th, k, alpha, hyst, nh, nl);
		int v[7];
		v = '{cal, abs_th, k, alpha, hyst, nh, nl};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1;
			cfg_index <= mpd_pkg::cfg_reg_t'(i);
			cfg_wdata <= mpd_pkg::CFG_DATA_W'(v[i]);
			@(posedge clk);
		end
		cfg_we <= 0;
		c_cal = 16'(cal);
		c_abs = 23'(abs_th);
		c_k = 12'(k);
		c_alpha = 16'(alpha);
		c_hyst = 16'(hyst);
		c_nh = 8'(nh);
		c_nl = 8'(nl);
	endtask

	task automatic drain();
		if (vld_on) begin
			s_tvalid <= 0;
			vld_on = 0;
		end
		while (pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send(input logic [23:0] smp, input logic [31:0] t, input bit typed,
			input result_t want);
		result_t r;
		int gap;
		s_tvalid <= 1;
		vld_on = 1;
		s_tdata <= {t, smp};
		do
			@(posedge clk);
		while (!s_tready);
		detect_step(smp, t, r);
		pending.push_back(typed ? want : r);
		gap = 0;
		if (mode == 0 && $urandom_range(99) < 32)
			gap = $urandom_range(1, 5);
		else if (mode == 1 && $urandom_range(99) < 83)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			s_tvalid <= 0;
			vld_on = 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	function automatic logic [23:0] next_sample();
		longint lvl, th, off;
		lvl = base >>> 16;
		th = (dth < 256) ? 256 : dth;
		if ($urandom_range(99) < 8)
			return 24'($urandom);
		if (burst_left > 0) begin
			burst_left--;
			off = burst_sign * th * longint'($urandom_range(100, 300)) / 100;
		end else begin
			if ($urandom_range(99) < 6)
				off = 0;
			else
				off = ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(0, th / 3));
			if ($urandom_range(19) == 0) begin
				burst_left = $urandom_range(1, c_nh + 6);
				burst_sign = $urandom_range(1) ? 1 : -1;
			end
		end
		return clamp24(lvl + off);
	endfunction

	always @(posedge clk) begin
		case (mode)
			0: m_tready <= ($urandom_range(99) >= 83);
			1: m_tready <= ($urandom_range(99) >= 32);
			default: m_tready <= 1;
		endcase
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, got %h", $time, m_tdata);
			end else begin
				e = pending.pop_front();
				if (m_tdata[2:0] !== e.ev) begin
					errors++;
					$display("%0t: event exp %0d got %0d", $time, e.ev, m_tdata[2:0]);
				end
				if (m_tdata[26:3] !== e.dev) begin
					errors++;
					$display("%0t: deviation exp %h got %h", $time, e.dev, m_tdata[26:3]);
				end
				if (m_tdata[50:27] !== e.base) begin
					errors++;
					$display("%0t: baseline exp %h got %h", $time, e.base, m_tdata[50:27]);
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		result_t cal_res;
		longint lvl;
		logic [23:0] smp;
		cal_res = '{mpd_pkg::EV_CALIBRATING, 24'd0, 24'd0};
		// window of 20 ms starting just below the timestamp wrap
		rows = '{
			'{0, 0,         32'hFFFF_FFF0, 1, cal_res},
			'{0, 8388607,   32'hFFFF_FFF2, 1, cal_res},
			'{0, -8388608,  32'hFFFF_FFF5, 1, cal_res},
			'{0, 1000,      32'hFFFF_FFF9, 1, cal_res},
			'{0, -1000,     32'hFFFF_FFFE, 1, cal_res},
			'{0, 500,       32'h0000_0001, 1, cal_res},
			'{0, 250,       32'h0000_0003, 1, cal_res},
			'{0, 200,       32'h0000_0004, 0, cal_res},
			'{0, 8388607,   32'h0000_0010, 0, cal_res},
			'{0, 8388607,   32'h0000_0011, 0, cal_res},
			'{0, 8388607,   32'h0000_0012, 0, cal_res},
			'{0, -8388608,  32'h0000_0013, 0, cal_res},
			'{1, 0,         32'h0000_0014, 0, cal_res},
			'{1, 10,        32'h0000_0015, 0, cal_res},
			'{1, -10,       32'h0000_0016, 0, cal_res},
			'{1, 0,         32'h0000_0017, 0, cal_res},
			'{1, 0,         32'hFFFF_FFFF, 0, cal_res},
			'{1, 0,         32'h0000_0000, 0, cal_res}
		};
		arst_n = 0;
		cfg_we <= 0;
		cfg_index <= mpd_pkg::REG_CAL_TIME;
		cfg_wdata <= 0;
		s_tvalid <= 0;
		s_tdata <= 0;
		started = 0; calibrated = 0; active = 0;
		t0 = 0; cnt = 0; dth = 0; mean = 0; base = 0; m2 = 0; hrun = 0; lrun = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			mode = ph / 2;
			case (ph)
				0: write_regs(20, 2560, 1, 655, 32768, 3, 5);
				1: write_regs(0, 8388607, 4095, 0, 65535, 1, 1);
				2: write_regs(65535, 0, 0, 65535, 0, 0, 2);
				3: write_regs(100, 1000, 2048, 0, 65535, 255, 255);
				4: write_regs(5000, 2560, 1024, 3000, 40000, 2, 3);
				default: write_regs(1, 1, 1, 655, 32768, 4, 0);
			endcase
			if (ph == 0) begin
				foreach (rows[i]) begin
					lvl = base >>> 16;
					smp = rows[i].rel ? clamp24(lvl + rows[i].smp) : rows[i].smp[23:0];
					send(smp, rows[i].t, rows[i].typed, rows[i].res);
				end
			end
			for (int n = 0; n < 306; n++)
				send(next_sample(), $urandom, 0, cal_res);
			drain();
		end

		if (errors == 0)
			$display("magnetic_presence_detector_core: match");
		else
			$display("magnetic_presence_detector_core: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mpd_pkg.sv
rtl/magnetic_presence_detector_core.sv
bench/tb.sv
